// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the two-class priority queue.
// Included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an implication holds at every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Check that a condition holds in the cycle after a trigger.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ===== rtl/tcpq_pkg.sv =====
// Shared types and codes for the two-class priority queue.
// No dependencies.
package tcpq_pkg;
	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_SERVE_PF = 2'd1;
	localparam logic [1:0] ACT_SERVE_OL = 2'd2;
	localparam logic [1:0] ACT_WITHDRAW = 2'd3;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_NEGATIVE  = 3'd1;
	localparam logic [2:0] ST_DUPLICATE = 3'd2;
	localparam logic [2:0] ST_FULL      = 3'd3;
	localparam logic [2:0] ST_EMPTY     = 3'd4;
	localparam logic [2:0] ST_NOT_FOUND = 3'd5;

	// controller -> datapath
	typedef struct packed {
		logic load;     // capture request, run compares
		logic commit;   // apply update, build result
	} tcpq_cmd_t;
endpackage

// ===== rtl/two_class_priority_queue.sv =====
// Top level of the two-class priority queue.
// Depends on tcpq_pkg, tcpq_ctrl and tcpq_datapath.
//
// Each request has a load step, which matches its id against every held
// slot and locates the oldest preferred entry, and a commit step, which
// applies the insert or shift-down removal. A new request is taken no earlier
// than the cycle its predecessor's result is taken, so requests never overlap.
// s_tdata: [1:0] action, [17:2] person_id, [18] is_preferred, zero to 24 bits.
// m_tdata: [2:0] status, [17:3] served_id, [22:18] total_count,
// [27:23] preferred_count, zero to 32 bits. No clearing pass after reset.
module two_class_priority_queue #(
	parameter int CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // action, person_id, is_preferred
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // status, served_id, total_count, preferred_count
);
	import tcpq_pkg::*;
	tcpq_cmd_t   cmd;
	logic [2:0]  status;
	logic [14:0] served_id;
	logic [4:0]  total_count, preferred_count;

	tcpq_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_tvalid), .in_ready(s_tready),
		.out_valid(m_tvalid), .out_ready(m_tready),
		.cmd
	);

	tcpq_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk, .arst_n, .cmd,
		.action(s_tdata[1:0]), .person_id(s_tdata[17:2]), .is_preferred(s_tdata[18]),
		.status, .served_id, .total_count, .preferred_count
	);

	assign m_tdata = {4'd0, preferred_count, total_count, served_id, status};
endmodule

// ===== rtl/tcpq_datapath.sv =====
// Datapath of the two-class priority queue: slot registers, compare and compaction.
// Depends on tcpq_pkg.
module tcpq_datapath #(
	parameter int CAPACITY = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tcpq_pkg::tcpq_cmd_t cmd,
	input  logic [1:0]          action,
	input  logic [15:0]         person_id,
	input  logic                is_preferred,
	output logic [2:0]          status,
	output logic [14:0]         served_id,
	output logic [4:0]          total_count,
	output logic [4:0]          preferred_count
);
	import tcpq_pkg::*;
	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [14:0]   slot_id_q [CAPACITY];
	logic [CAPACITY-1:0] slot_pref_q;
	logic [CW-1:0] occ_q, pcnt_q;

	logic [1:0]    act_s1;
	logic [14:0]   id_s1;
	logic          neg_s1, pref_s1;
	logic          hit_s1, anyp_s1;
	logic [IW-1:0] hit_pos_s1, pref_pos_s1;

	// stage 1: parallel match and first-preferred search
	logic [CAPACITY-1:0] match, pmask;
	logic [IW-1:0] mpos, ppos;
	always_comb begin
		mpos = '0;
		ppos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			match[i] = (CW'(i) < occ_q) && (slot_id_q[i] == person_id[14:0]);
			pmask[i] = (CW'(i) < occ_q) && slot_pref_q[i];
		end
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (match[i]) mpos = IW'(i);
			if (pmask[i]) ppos = IW'(i);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_s1      <= action;
			id_s1       <= person_id[14:0];
			neg_s1      <= person_id[15];
			pref_s1     <= is_preferred;
			hit_s1      <= |match;
			anyp_s1     <= |pmask;
			hit_pos_s1  <= mpos;
			pref_pos_s1 <= ppos;
		end
	end

	// stage 2: decide and compact
	logic          do_ins, do_rem;
	logic [IW-1:0] rpos;
	logic [2:0]    st;
	always_comb begin
		do_ins = 1'b0;
		do_rem = 1'b0;
		rpos   = '0;
		st     = ST_OK;
		unique case (act_s1)
			ACT_INSERT: begin
				if (neg_s1) st = ST_NEGATIVE;
				else if (hit_s1) st = ST_DUPLICATE;
				else if (occ_q == CW'(CAPACITY)) st = ST_FULL;
				else do_ins = 1'b1;
			end
			ACT_SERVE_PF, ACT_SERVE_OL: begin
				if (occ_q == '0) st = ST_EMPTY;
				else begin
					do_rem = 1'b1;
					rpos = (act_s1 == ACT_SERVE_PF && anyp_s1) ? pref_pos_s1 : '0;
				end
			end
			default: begin
				if (neg_s1 || !hit_s1) st = ST_NOT_FOUND;
				else begin
					do_rem = 1'b1;
					rpos = hit_pos_s1;
				end
			end
		endcase
	end

	logic rem_pref;
	assign rem_pref = slot_pref_q[rpos];

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (do_ins) begin
				slot_id_q[occ_q[IW-1:0]] <= id_s1;
				slot_pref_q[occ_q[IW-1:0]] <= pref_s1;
			end else if (do_rem) begin
				for (int i = 0; i < CAPACITY - 1; i++) begin
					if (IW'(i) >= rpos) begin
						slot_id_q[i]   <= slot_id_q[i+1];
						slot_pref_q[i] <= slot_pref_q[i+1];
					end
				end
			end
			status    <= st;
			served_id <= (do_rem && act_s1 != ACT_WITHDRAW) ? slot_id_q[rpos] : 15'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q  <= '0;
			pcnt_q <= '0;
		end else if (cmd.commit) begin
			if (do_ins) begin
				occ_q  <= occ_q + 1'b1;
				pcnt_q <= pcnt_q + CW'(pref_s1);
			end else if (do_rem) begin
				occ_q  <= occ_q - 1'b1;
				pcnt_q <= pcnt_q - CW'(rem_pref);
			end
		end
	end

	assign total_count     = 5'(occ_q);
	assign preferred_count = 5'(pcnt_q);

	`include "assert_macros.svh"
	`ASSERT_IMP(a_pcnt_le_occ, clk, arst_n, 1'b1, pcnt_q <= occ_q)
	`ASSERT_IMP(a_occ_max, clk, arst_n, 1'b1, occ_q <= CW'(CAPACITY))
	`ASSERT_NEXT(a_ins_grows, clk, arst_n, cmd.commit && do_ins, occ_q == $past(occ_q) + 1'b1)
endmodule

// ===== rtl/tcpq_ctrl.sv =====
// Controller of the two-class priority queue: handshake and step sequencing.
// Depends on tcpq_pkg.
module tcpq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output tcpq_pkg::tcpq_cmd_t cmd
);
	import tcpq_pkg::*;
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_EXEC = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;

	// accept the next request while a result waits, as long as it gets taken
	assign in_ready   = (state_q == S_IDLE) || (state_q == S_OUT && out_ready);
	assign out_valid  = (state_q == S_OUT);
	assign cmd.load   = in_valid && in_ready;
	assign cmd.commit = (state_q == S_EXEC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_EXEC;
				S_EXEC: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) state_q <= in_valid ? S_EXEC : S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "assert_macros.svh"
	`ASSERT_NEXT(a_load_exec, clk, arst_n, cmd.load, state_q == S_EXEC)
	`ASSERT_IMP(a_no_load_exec, clk, arst_n, state_q == S_EXEC, !in_ready)
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
endmodule
